// ----- rtl/mtmb_pkg.sv -----
// ============================================================================
// mtmb_pkg: shared types and constants for the model transform matrix builder
// Holds the CORDIC constants, the arctangent table and the beat structs.
// ============================================================================
package mtmb_pkg;

   localparam int TurnUnits    = 23040;
   localparam int QuarterUnits = 5760;
   localparam int CordicSteps  = 16;
   localparam int QueueDepth   = 2;

   localparam logic signed [27:0] CordicGain = 28'sd10188014;
   localparam logic signed [23:0] OutMax     = 24'sh7FFFFF;
   localparam logic signed [23:0] OutMin     = -24'sh800000;

   typedef logic [3:0] step_type;

   // Engine sequencer states
   typedef enum logic [1:0] {IDLE, ROTATE, MULT, DONE} state_type;

   // Input beat captured by the front end
   typedef struct packed {
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
   } geo_type;

   // Reduced angle: quadrant and remainder
   typedef struct packed {
      logic [1:0]  quad;
      logic [12:0] rem;
   } red_type;

   // Queue entry between front and back
   typedef struct packed {
      geo_type geo;
      red_type ax;
      red_type ay;
      red_type az;
   } job_type;

   // Result beat
   typedef struct packed {
      logic signed [23:0] r0c0, r0c1, r0c2, r0c3;
      logic signed [23:0] r1c0, r1c1, r1c2, r1c3;
      logic signed [23:0] r2c0, r2c1, r2c2, r2c3;
   } mat_type;

   // atan(2^-i) in units of 2^-16 degree
   function automatic logic signed [23:0] atan_lut(input step_type i);
      logic signed [23:0] v;
      begin
         case (i)
            4'd0: v = 24'sd2949120;
            4'd1: v = 24'sd1740967;
            4'd2: v = 24'sd919879;
            4'd3: v = 24'sd466945;
            4'd4: v = 24'sd234379;
            4'd5: v = 24'sd117304;
            4'd6: v = 24'sd58666;
            4'd7: v = 24'sd29335;
            4'd8: v = 24'sd14668;
            4'd9: v = 24'sd7334;
            4'd10: v = 24'sd3667;
            4'd11: v = 24'sd1833;
            4'd12: v = 24'sd917;
            4'd13: v = 24'sd458;
            4'd14: v = 24'sd229;
            default: v = 24'sd115;
         endcase
         return v;
      end
   endfunction

   // Reduce one angle modulo a turn and split into quadrant and remainder
   function automatic red_type reduce(input logic signed [15:0] a);
      logic signed [17:0] r;
      red_type o;
      begin
         // a in [-32768,32767]; add two turns, then subtract two turns and one turn where needed
         r = 18'(a) + 18'sd46080;
         if (r >= 18'sd46080) r = r - 18'sd46080;
         if (r >= 18'sd23040) r = r - 18'sd23040;
         o.quad = 2'd0;
         if (r >= 18'sd17280) begin
            o.quad = 2'd3; r = r - 18'sd17280;
         end else if (r >= 18'sd11520) begin
            o.quad = 2'd2; r = r - 18'sd11520;
         end else if (r >= 18'sd5760) begin
            o.quad = 2'd1; r = r - 18'sd5760;
         end
         o.rem = r[12:0];
         return o;
      end
   endfunction

   // Saturate a wide value to the output range
   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      begin
         if (v > 48'(OutMax)) return OutMax;
         if (v < 48'(OutMin)) return OutMin;
         return v[23:0];
      end
   endfunction

endpackage

// ----- rtl/mtmb_front.sv -----
// ============================================================================
// mtmb_front: input stage
// Accepts one beat, reduces the three angles and pushes a job to the queue.
// ============================================================================
module mtmb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [15:0]     req_scale_x,
   input  logic signed [15:0]     req_scale_y,
   input  logic signed [15:0]     req_scale_z,
   input  logic signed [15:0]     req_pos_x,
   input  logic signed [15:0]     req_pos_y,
   input  logic signed [15:0]     req_pos_z,
   input  logic signed [15:0]     req_angle_x,
   input  logic signed [15:0]     req_angle_y,
   input  logic signed [15:0]     req_angle_z,
   output logic                   job_valid,
   input  logic                   job_ready,
   output mtmb_pkg::job_type      job_data
);
   import mtmb_pkg::*;

   logic    full_ff, full_in;
   job_type job_ff, job_in;

   // hold the staged job until the queue takes it
   assign req_stall = full_ff && !job_ready;
   assign job_valid = full_ff;
   assign job_data  = job_ff;

   always_comb begin
      full_in = full_ff;
      job_in  = job_ff;
      if (full_ff && job_ready) full_in = 1'b0;
      if (req_valid && !req_stall) begin
         full_in = 1'b1;
         job_in.geo.scale_x = req_scale_x;
         job_in.geo.scale_y = req_scale_y;
         job_in.geo.scale_z = req_scale_z;
         job_in.geo.pos_x   = req_pos_x;
         job_in.geo.pos_y   = req_pos_y;
         job_in.geo.pos_z   = req_pos_z;
         job_in.ax = reduce(req_angle_x);
         job_in.ay = reduce(req_angle_y);
         job_in.az = reduce(req_angle_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      job_ff <= job_in;
   end
endmodule

// ----- rtl/mtmb_queue.sv -----
// ============================================================================
// mtmb_queue: short job queue
// Two-entry register FIFO between the front end and the back end.
// ============================================================================
module mtmb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mtmb_pkg::job_type  push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mtmb_pkg::job_type  pop_data
);
   import mtmb_pkg::*;

   job_type    mem_ff [QueueDepth];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign push_ready = (cnt_ff != 2'(QueueDepth));
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // advance pointers and count
   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= push_data;
   end
endmodule

// ----- rtl/mtmb_back.sv -----
// ============================================================================
// mtmb_back: matrix engine
// Runs three CORDIC rotators in parallel for 16 steps, then a sequence of
// multiply steps that forms Rz*Ry*Rx, scales the columns and saturates.
// ============================================================================
module mtmb_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  mtmb_pkg::job_type  job_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mtmb_pkg::mat_type  rsp_data
);
   import mtmb_pkg::*;

   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   geo_type            geo_ff, geo_in;
   red_type            q_ff [3];
   red_type            q_in [3];
   logic signed [27:0] x_ff [3];
   logic signed [27:0] x_in [3];
   logic signed [27:0] y_ff [3];
   logic signed [27:0] y_in [3];
   logic signed [24:0] z_ff [3];
   logic signed [24:0] z_in [3];
   logic signed [17:0] s_ff [3];
   logic signed [17:0] s_in [3];
   logic signed [17:0] c_ff [3];
   logic signed [17:0] c_in [3];
   // a = Ry*Rx terms needed, rotation elements
   logic signed [17:0] rot_ff [9];
   logic signed [17:0] rot_in [9];
   logic signed [17:0] t_ff [4];
   logic signed [17:0] t_in [4];
   mat_type            out_ff, out_in;
   logic               ov_ff, ov_in;
   logic               take;

   assign job_ready = (state_ff == IDLE);
   assign take      = job_valid && job_ready;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   // round Q.16, clamp to +-1, then place in quadrant
   function automatic void fin(input logic signed [27:0] x, input logic signed [27:0] y,
                               input logic [1:0] q, output logic signed [17:0] s,
                               output logic signed [17:0] c);
      logic signed [19:0] cr, sr;
      begin
         cr = 20'((x + 28'sd128) >>> 8);
         sr = 20'((y + 28'sd128) >>> 8);
         if (cr > 20'sd65536) cr = 20'sd65536;
         if (cr < -20'sd65536) cr = -20'sd65536;
         if (sr > 20'sd65536) sr = 20'sd65536;
         if (sr < -20'sd65536) sr = -20'sd65536;
         case (q)
            2'd0: begin c = cr[17:0];  s = sr[17:0];  end
            2'd1: begin c = -sr[17:0]; s = cr[17:0];  end
            2'd2: begin c = -cr[17:0]; s = -sr[17:0]; end
            default: begin c = sr[17:0]; s = -cr[17:0]; end
         endcase
      end
   endfunction

   function automatic logic signed [17:0] rnd16(input logic signed [37:0] v);
      return 18'((v + 38'sd32768) >>> 16);
   endfunction

   function automatic logic signed [23:0] scl(input logic signed [17:0] r,
                                            input logic signed [15:0] k);
      logic signed [33:0] p;
      begin
         p = r * k;
         return sat24(48'((p + 34'sd2048) >>> 12));
      end
   endfunction

   always_comb begin
      logic signed [27:0] dx, dy;
      logic signed [35:0] p0, p1;
      dx       = '0;
      dy       = '0;
      p0       = '0;
      p1       = '0;
      state_in = state_ff;
      step_in  = step_ff;
      geo_in   = geo_ff;
      q_in     = q_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      s_in     = s_ff;
      c_in     = c_ff;
      rot_in   = rot_ff;
      t_in     = t_ff;
      out_in   = out_ff;
      ov_in    = ov_ff;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      case (state_ff)
         IDLE: begin
            if (take) begin
               geo_in = job_data.geo;
               q_in[0] = job_data.ax;
               q_in[1] = job_data.ay;
               q_in[2] = job_data.az;
               for (int k = 0; k < 3; k++) begin
                  x_in[k] = CordicGain;
                  y_in[k] = 28'sd0;
                  z_in[k] = 25'({q_in[k].rem, 10'd0});
               end
               step_in  = 4'd0;
               state_in = ROTATE;
            end
         end
         ROTATE: begin
            // one CORDIC micro-rotation per cycle on all three angles
            for (int k = 0; k < 3; k++) begin
               dx = y_ff[k] >>> step_ff;
               dy = x_ff[k] >>> step_ff;
               if (!z_ff[k][24]) begin
                  x_in[k] = x_ff[k] - dx;
                  y_in[k] = y_ff[k] + dy;
                  z_in[k] = z_ff[k] - 25'(atan_lut(step_ff));
               end else begin
                  x_in[k] = x_ff[k] + dx;
                  y_in[k] = y_ff[k] - dy;
                  z_in[k] = z_ff[k] + 25'(atan_lut(step_ff));
               end
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(CordicSteps - 1)) begin
               step_in  = 4'd0;
               state_in = MULT;
            end
         end
         MULT: begin
            // x axis = 0, y = 1, z = 2; steps before the last use at most three products each
            case (step_ff)
               4'd0: for (int k = 0; k < 3; k++) begin
                  fin(x_ff[k], y_ff[k], q_ff[k].quad, s_in[k], c_in[k]);
               end
               4'd1: begin
                  // a = Ry*Rx: a01 = -sy*sx, a02 = sy*cx
                  p0 = s_ff[1] * s_ff[0];
                  p1 = s_ff[1] * c_ff[0];
                  t_in[0] = rnd16(-38'(p0));
                  t_in[1] = rnd16(38'(p1));
               end
               4'd2: begin
                  // a21 = -cy*sx, a22 = cy*cx
                  p0 = c_ff[1] * s_ff[0];
                  p1 = c_ff[1] * c_ff[0];
                  t_in[2] = rnd16(-38'(p0));
                  t_in[3] = rnd16(38'(p1));
               end
               4'd3: begin
                  // row 0: cz*a0c + sz*a1c ; a00=cy, a10=0, a11=cx, a12=sx
                  p0 = c_ff[2] * c_ff[1];
                  rot_in[0] = rnd16(38'(p0));
                  p0 = c_ff[2] * t_ff[0];
                  p1 = s_ff[2] * c_ff[0];
                  rot_in[1] = rnd16(38'(p0) + 38'(p1));
               end
               4'd4: begin
                  p0 = c_ff[2] * t_ff[1];
                  p1 = s_ff[2] * s_ff[0];
                  rot_in[2] = rnd16(38'(p0) + 38'(p1));
                  p0 = -s_ff[2] * c_ff[1];
                  rot_in[3] = rnd16(38'(p0));
               end
               4'd5: begin
                  p0 = -s_ff[2] * t_ff[0];
                  p1 = c_ff[2] * c_ff[0];
                  rot_in[4] = rnd16(38'(p0) + 38'(p1));
               end
               4'd6: begin
                  p0 = -s_ff[2] * t_ff[1];
                  p1 = c_ff[2] * s_ff[0];
                  rot_in[5] = rnd16(38'(p0) + 38'(p1));
                  // row 2: a20 = -sy, a21, a22 (times 1.0 exactly)
                  rot_in[6] = -s_ff[1];
                  rot_in[7] = t_ff[2];
                  rot_in[8] = t_ff[3];
               end
               default: begin
                  // scale the columns once the output register is free
                  if (!ov_in) begin
                     out_in.r0c0 = scl(rot_ff[0], geo_ff.scale_x);
                     out_in.r0c1 = scl(rot_ff[1], geo_ff.scale_y);
                     out_in.r0c2 = scl(rot_ff[2], geo_ff.scale_z);
                     out_in.r1c0 = scl(rot_ff[3], geo_ff.scale_x);
                     out_in.r1c1 = scl(rot_ff[4], geo_ff.scale_y);
                     out_in.r1c2 = scl(rot_ff[5], geo_ff.scale_z);
                     out_in.r2c0 = scl(rot_ff[6], geo_ff.scale_x);
                     out_in.r2c1 = scl(rot_ff[7], geo_ff.scale_y);
                     out_in.r2c2 = scl(rot_ff[8], geo_ff.scale_z);
                     out_in.r0c3 = {{4{geo_ff.pos_x[15]}}, geo_ff.pos_x, 4'd0};
                     out_in.r1c3 = {{4{geo_ff.pos_y[15]}}, geo_ff.pos_y, 4'd0};
                     out_in.r2c3 = {{4{geo_ff.pos_z[15]}}, geo_ff.pos_z, 4'd0};
                     ov_in    = 1'b1;
                     state_in = IDLE;
                  end
               end
            endcase
            if (step_ff != 4'd7) step_in = step_ff + 4'd1;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ov_ff    <= 1'b0;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         step_ff  <= step_in;
      end
      geo_ff <= geo_in;
      q_ff   <= q_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      s_ff   <= s_in;
      c_ff   <= c_in;
      rot_ff <= rot_in;
      t_ff   <= t_in;
      out_ff <= out_in;
   end
endmodule

// ----- rtl/model_transform_matrix_builder.sv -----
// ============================================================================
// model_transform_matrix_builder: top level
// Builds the top three rows of M = T * Rz * Ry * Rx * S from one request beat.
// ----------------------------------------------------------------------------
// Request channel (req_*): scale, translation and Euler angles in 1/64 degree.
// A beat is taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): twelve Q7.16 matrix terms, saturated, one beat
// per request, in request order. The receiver holds rsp_stall to pause it;
// the finished beat then stays in the output register.
// The front stage reduces the angles and places the job in a two-entry
// queue; the engine behind it runs three CORDIC units for 16 steps and then
// 8 multiply steps, at most three multipliers wide before the last step,
// which scales all nine terms. The engine takes the next job only after it
// has placed the previous matrix in the output register.
// The request side accepts beats until the queue and front stage are full.
// Reset (synchronous, active high) empties the queue and drops any result.
// ============================================================================
module model_transform_matrix_builder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [15:0] req_scale_z,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_angle_x,
   input  logic signed [15:0] req_angle_y,
   input  logic signed [15:0] req_angle_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_m_r0c0,
   output logic signed [23:0] rsp_m_r0c1,
   output logic signed [23:0] rsp_m_r0c2,
   output logic signed [23:0] rsp_m_r0c3,
   output logic signed [23:0] rsp_m_r1c0,
   output logic signed [23:0] rsp_m_r1c1,
   output logic signed [23:0] rsp_m_r1c2,
   output logic signed [23:0] rsp_m_r1c3,
   output logic signed [23:0] rsp_m_r2c0,
   output logic signed [23:0] rsp_m_r2c1,
   output logic signed [23:0] rsp_m_r2c2,
   output logic signed [23:0] rsp_m_r2c3
);
   import mtmb_pkg::*;

   logic    f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;
   mat_type mat;

   mtmb_front u_front (
      .clock, .reset, .req_valid, .req_stall,
      .req_scale_x, .req_scale_y, .req_scale_z,
      .req_pos_x, .req_pos_y, .req_pos_z,
      .req_angle_x, .req_angle_y, .req_angle_z,
      .job_valid(f_valid), .job_ready(f_ready), .job_data(f_job)
   );

   mtmb_queue u_queue (
      .clock, .reset,
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_job),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_job)
   );

   mtmb_back u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_ready(b_ready), .job_data(b_job),
      .rsp_valid, .rsp_stall, .rsp_data(mat)
   );

   assign rsp_m_r0c0 = mat.r0c0;
   assign rsp_m_r0c1 = mat.r0c1;
   assign rsp_m_r0c2 = mat.r0c2;
   assign rsp_m_r0c3 = mat.r0c3;
   assign rsp_m_r1c0 = mat.r1c0;
   assign rsp_m_r1c1 = mat.r1c1;
   assign rsp_m_r1c2 = mat.r1c2;
   assign rsp_m_r1c3 = mat.r1c3;
   assign rsp_m_r2c0 = mat.r2c0;
   assign rsp_m_r2c1 = mat.r2c1;
   assign rsp_m_r2c2 = mat.r2c2;
   assign rsp_m_r2c3 = mat.r2c3;
endmodule

// ----- bench/mtmb_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// mtmb_checker: matrix predictor and response scoreboard
// Watches both channels, computes the expected matrix for each request beat
// in fixed point and compares every response beat term by term.
// ============================================================================
module mtmb_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [15:0] req_scale_z,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_angle_x,
   input  logic signed [15:0] req_angle_y,
   input  logic signed [15:0] req_angle_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [23:0] rsp_m_r0c0,
   input  logic signed [23:0] rsp_m_r0c1,
   input  logic signed [23:0] rsp_m_r0c2,
   input  logic signed [23:0] rsp_m_r0c3,
   input  logic signed [23:0] rsp_m_r1c0,
   input  logic signed [23:0] rsp_m_r1c1,
   input  logic signed [23:0] rsp_m_r1c2,
   input  logic signed [23:0] rsp_m_r1c3,
   input  logic signed [23:0] rsp_m_r2c0,
   input  logic signed [23:0] rsp_m_r2c1,
   input  logic signed [23:0] rsp_m_r2c2,
   input  logic signed [23:0] rsp_m_r2c3,
   output int                 fail_count,
   output int                 pending_count
);
   import mtmb_pkg::*;

   typedef logic signed [63:0] wide_type;
   typedef wide_type mat3_type [3][3];

   const wide_type atan_deg [16] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

   mat_type expected_matrices [$];

   function automatic wide_type floor_div(wide_type v, int n);
      return v >>> n;
   endfunction

   function automatic wide_type round_div(wide_type v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic wide_type clip(wide_type v, wide_type lo, wide_type hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Quadrant-reduced CORDIC sine and cosine, Q.16
   task automatic angle_trig(input logic signed [15:0] a, output wide_type s,
                             output wide_type c);
      wide_type r, q, x, y, z, dx, dy, cc, ss;
      r = (wide_type'(a) + 2 * TurnUnits) % TurnUnits;
      q = r / QuarterUnits;
      x = 10188014;
      y = 0;
      z = (r - q * QuarterUnits) * 1024;
      for (int i = 0; i < 16; i++) begin
         dx = floor_div(y, i);
         dy = floor_div(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_deg[i];
         end else begin
            x += dx; y -= dy; z += atan_deg[i];
         end
      end
      cc = clip(round_div(x, 8), -65536, 65536);
      ss = clip(round_div(y, 8), -65536, 65536);
      case (q)
         0: begin c = cc; s = ss; end
         1: begin c = -ss; s = cc; end
         2: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
   endtask

   function automatic mat3_type mat_mul(mat3_type a, mat3_type b);
      mat3_type p;
      wide_type acc;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += a[r][k] * b[k][c];
            p[r][c] = round_div(acc, 16);
         end
      return p;
   endfunction

   function automatic logic signed [23:0] sat_term(wide_type v);
      return 24'(clip(v, -8388608, 8388607));
   endfunction

   task automatic build_matrix(output mat_type m);
      wide_type sx, cx, sy, cy, sz, cz;
      wide_type scl [3];
      wide_type pos [3];
      mat3_type rx, ry, rz, rot;
      logic signed [23:0] t [3][4];
      angle_trig(req_angle_x, sx, cx);
      angle_trig(req_angle_y, sy, cy);
      angle_trig(req_angle_z, sz, cz);
      scl = '{req_scale_x, req_scale_y, req_scale_z};
      pos = '{req_pos_x, req_pos_y, req_pos_z};
      rx = '{'{65536, 0, 0}, '{0, cx, sx}, '{0, -sx, cx}};
      ry = '{'{cy, 0, sy}, '{0, 65536, 0}, '{-sy, 0, cy}};
      rz = '{'{cz, sz, 0}, '{-sz, cz, 0}, '{0, 0, 65536}};
      rot = mat_mul(rz, mat_mul(ry, rx));
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) t[r][c] = sat_term(round_div(rot[r][c] * scl[c], 12));
         t[r][3] = sat_term(pos[r] * 16);
      end
      m = '{t[0][0], t[0][1], t[0][2], t[0][3], t[1][0], t[1][1], t[1][2], t[1][3],
            t[2][0], t[2][1], t[2][2], t[2][3]};
   endtask

   task automatic compare_term(string name, logic signed [23:0] exp_v,
                               logic signed [23:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Predict on request beats, compare on response beats
   always @(posedge clock) begin
      mat_type m;
      if (!reset && req_valid && !req_stall) begin
         build_matrix(m);
         expected_matrices.push_back(m);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matrices.size() == 0) begin
            fail_count++;
            $display("%0t unexpected response beat, expected none actual r0c0 %0d",
                     $time, rsp_m_r0c0);
         end else begin
            m = expected_matrices.pop_front();
            compare_term("r0c0", m.r0c0, rsp_m_r0c0);
            compare_term("r0c1", m.r0c1, rsp_m_r0c1);
            compare_term("r0c2", m.r0c2, rsp_m_r0c2);
            compare_term("r0c3", m.r0c3, rsp_m_r0c3);
            compare_term("r1c0", m.r1c0, rsp_m_r1c0);
            compare_term("r1c1", m.r1c1, rsp_m_r1c1);
            compare_term("r1c2", m.r1c2, rsp_m_r1c2);
            compare_term("r1c3", m.r1c3, rsp_m_r1c3);
            compare_term("r2c0", m.r2c0, rsp_m_r2c0);
            compare_term("r2c1", m.r2c1, rsp_m_r2c1);
            compare_term("r2c2", m.r2c2, rsp_m_r2c2);
            compare_term("r2c3", m.r2c3, rsp_m_r2c3);
         end
      end
      pending_count = expected_matrices.size();
   end

endmodule

// ----- bench/tb_model_transform_matrix_builder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_model_transform_matrix_builder: top of the matrix builder bench
// Drives directed and random request beats with random gaps and response
// stalls, including one long hold-off, and reports the verdict.
// ============================================================================
module tb_model_transform_matrix_builder;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_stall = 1'b0;
   logic req_stall, rsp_valid;
   logic signed [15:0] req_field [9];
   logic signed [23:0] rsp_m [12];
   int fail_count, pending_count;
   int idle_cycles = 0;
   bit stim_done = 1'b0;

   initial for (int i = 0; i < 9; i++) req_field[i] = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   model_transform_matrix_builder DUT (
      .clock, .reset, .req_valid, .req_stall,
      .req_scale_x(req_field[0]), .req_scale_y(req_field[1]), .req_scale_z(req_field[2]),
      .req_pos_x(req_field[3]), .req_pos_y(req_field[4]), .req_pos_z(req_field[5]),
      .req_angle_x(req_field[6]), .req_angle_y(req_field[7]), .req_angle_z(req_field[8]),
      .rsp_valid, .rsp_stall,
      .rsp_m_r0c0(rsp_m[0]), .rsp_m_r0c1(rsp_m[1]), .rsp_m_r0c2(rsp_m[2]),
      .rsp_m_r0c3(rsp_m[3]), .rsp_m_r1c0(rsp_m[4]), .rsp_m_r1c1(rsp_m[5]),
      .rsp_m_r1c2(rsp_m[6]), .rsp_m_r1c3(rsp_m[7]), .rsp_m_r2c0(rsp_m[8]),
      .rsp_m_r2c1(rsp_m[9]), .rsp_m_r2c2(rsp_m[10]), .rsp_m_r2c3(rsp_m[11])
   );

   mtmb_checker checker_i (
      .clock, .reset, .req_valid, .req_stall,
      .req_scale_x(req_field[0]), .req_scale_y(req_field[1]), .req_scale_z(req_field[2]),
      .req_pos_x(req_field[3]), .req_pos_y(req_field[4]), .req_pos_z(req_field[5]),
      .req_angle_x(req_field[6]), .req_angle_y(req_field[7]), .req_angle_z(req_field[8]),
      .rsp_valid, .rsp_stall,
      .rsp_m_r0c0(rsp_m[0]), .rsp_m_r0c1(rsp_m[1]), .rsp_m_r0c2(rsp_m[2]),
      .rsp_m_r0c3(rsp_m[3]), .rsp_m_r1c0(rsp_m[4]), .rsp_m_r1c1(rsp_m[5]),
      .rsp_m_r1c2(rsp_m[6]), .rsp_m_r1c3(rsp_m[7]), .rsp_m_r2c0(rsp_m[8]),
      .rsp_m_r2c1(rsp_m[9]), .rsp_m_r2c2(rsp_m[10]), .rsp_m_r2c3(rsp_m[11]),
      .fail_count, .pending_count
   );

   // Offer one request beat after a gap and hold it until accepted
   task automatic send_beat(input logic signed [15:0] f [9]);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 9; i++) req_field[i] <= f[i];
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [15:0] rand_scalar();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return -16'sh8000;
         2: return 16'(int'($urandom_range(0, 8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 6) * 5760 - 17280);
         1: return 16'(int'($urandom_range(0, 46080)) - 23040);
         default: return 16'($urandom);
      endcase
   endfunction

   // Stimulus: directed corners, then random beats
   initial begin
      logic signed [15:0] f [9];
      logic signed [15:0] corner [8];
      corner = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh1000, -16'sh1000,
                 16'sd5760, 16'sd23040, -16'sd5760};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // zero angles, extremes, quarter turns, wraps, saturating scales
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 9; i++) f[i] = corner[(k + i) % 8];
         send_beat(f);
      end
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 6; i++) f[i] = (k % 2) ? 16'sh7FFF : -16'sh8000;
         for (int i = 6; i < 9; i++) f[i] = corner[(k + i) % 8];
         send_beat(f);
      end
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 9; i++) f[i] = 16'sh1000;
         f[6 + k % 3] = 16'(k * 5760 + 2880);
         send_beat(f);
      end
      for (int n = 0; n < 430; n++) begin
         for (int i = 0; i < 6; i++) f[i] = rand_scalar();
         for (int i = 6; i < 9; i++) f[i] = rand_angle();
         send_beat(f);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Response stalls, with one long hold-off partway through
   initial begin
      int hold;
      @(negedge reset);
      repeat (300) @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (400) @(posedge clock);
      forever begin
         hold = $urandom_range(0, 13);
         if ($urandom_range(0, 2) == 0) hold = 0;
         rsp_stall <= (hold != 0);
         if (hold != 0) begin
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Verdict once everything has drained
   initial begin
      wait (stim_done);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
